// ===== src/mbrtu_pkg.sv =====
// shared types, constants and the byte-wide crc-16 update for the modbus rtu frame checker
// no dependencies; used by every module under src
package mbrtu_pkg;

  localparam int MAX_FRAME = 256;
  localparam int CNT_W     = $clog2(MAX_FRAME + 2);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [CNT_W-1:0] MIN_FRAME  = CNT_W'(4);
  localparam logic [CNT_W-1:0] MAX_LEN    = CNT_W'(MAX_FRAME);
  localparam logic [CNT_W-1:0] CNT_SAT    = CNT_W'(MAX_FRAME + 1);
  localparam logic [CNT_W-1:0] IDX_LAST   = CNT_W'(MAX_FRAME - 1);
  localparam logic [CNT_W-1:0] HDR_TRL    = CNT_W'(3);
  localparam logic [7:0] BROADCAST_ADDR   = 8'h00;
  localparam logic [7:0] SLAVE_ADDR_RST   = 8'h01;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_frame;
    logic       line_error;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic        frame_done;
    logic        frame_valid;
    logic        for_this_slave;
    logic        is_broadcast;
    logic [7:0]  pdu_length;
    logic [15:0] bus_message_count;
    logic [15:0] bus_error_count;
    logic [15:0] slave_message_count;
    logic [15:0] no_response_count;
  } result_t;

  // reflected crc-16/modbus, one byte, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== src/mbrtu_in_stage.sv =====
// input register for received byte requests
// depends on mbrtu_pkg (in_item_t)
module mbrtu_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_rx_byte,
  input  logic                 in_end_of_frame,
  input  logic                 in_line_error,
  input  logic                 take,
  output logic                 item_valid,
  output mbrtu_pkg::in_item_t  item
);

  logic                valid_r;
  mbrtu_pkg::in_item_t item_r;

  // refill in the same cycle the held request moves on
  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.rx_byte      <= in_rx_byte;
      item_r.end_of_frame <= in_end_of_frame;
      item_r.line_error   <= in_line_error;
    end
  end

endmodule

// ===== src/mbrtu_frame_core.sv =====
// frame state, crc update, verdict and message counters for one byte a cycle while step is high
// depends on mbrtu_pkg (types, constants, crc_byte)
module mbrtu_frame_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  mbrtu_pkg::in_item_t  item,
  input  logic [7:0]           slave_address,
  output mbrtu_pkg::result_t   result
);

  logic [15:0]                  crc_r, crc_nxt;
  logic [mbrtu_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [7:0]                   addr_r, addr_nxt;
  logic                         err_r, err_nxt;
  logic [15:0]                  bus_msg_r, bus_msg_nxt;
  logic [15:0]                  bus_err_r, bus_err_nxt;
  logic [15:0]                  slv_msg_r, slv_msg_nxt;
  logic [15:0]                  no_rsp_r, no_rsp_nxt;
  logic [15:0]                  crc_upd;
  logic [mbrtu_pkg::CNT_W-1:0]  len;
  logic [mbrtu_pkg::CNT_W-1:0]  idx;
  logic [mbrtu_pkg::CNT_W-1:0]  pdu;
  logic [7:0]                   addr_cur;
  logic                         err_cur;
  logic                         valid;
  logic                         mine;
  logic                         bcast;

  always_comb begin
    addr_cur = (cnt_r == '0) ? item.rx_byte : addr_r;
    err_cur  = err_r || item.line_error;
    crc_upd  = mbrtu_pkg::crc_byte(crc_r, item.rx_byte);
    len      = (cnt_r < mbrtu_pkg::CNT_SAT) ? cnt_r + 1'b1 : cnt_r;
    idx      = (cnt_r > mbrtu_pkg::IDX_LAST) ? mbrtu_pkg::IDX_LAST : cnt_r;
    pdu      = len - mbrtu_pkg::HDR_TRL;

    valid = item.end_of_frame && (len >= mbrtu_pkg::MIN_FRAME) &&
            (len <= mbrtu_pkg::MAX_LEN) && !err_cur && (crc_upd == 16'h0000);
    mine  = valid && ((addr_cur == slave_address) ||
                      (addr_cur == mbrtu_pkg::BROADCAST_ADDR));
    bcast = mine && (addr_cur == mbrtu_pkg::BROADCAST_ADDR);

    bus_msg_nxt = bus_msg_r + {15'd0, valid};
    bus_err_nxt = bus_err_r + {15'd0, item.end_of_frame && !valid};
    slv_msg_nxt = slv_msg_r + {15'd0, mine};
    no_rsp_nxt  = no_rsp_r  + {15'd0, bcast};

    // last byte puts the frame state back to its idle values
    if (item.end_of_frame) begin
      crc_nxt  = mbrtu_pkg::CRC_INIT;
      cnt_nxt  = '0;
      addr_nxt = 8'h00;
      err_nxt  = 1'b0;
    end else begin
      crc_nxt  = crc_upd;
      cnt_nxt  = len;
      addr_nxt = addr_cur;
      err_nxt  = err_cur;
    end

    result.data_byte           = item.rx_byte;
    result.byte_index          = idx[7:0];
    result.frame_done          = item.end_of_frame;
    result.frame_valid         = valid;
    result.for_this_slave      = mine;
    result.is_broadcast        = bcast;
    result.pdu_length          = valid ? pdu[7:0] : 8'h00;
    result.bus_message_count   = bus_msg_nxt;
    result.bus_error_count     = bus_err_nxt;
    result.slave_message_count = slv_msg_nxt;
    result.no_response_count   = no_rsp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r     <= mbrtu_pkg::CRC_INIT;
      cnt_r     <= '0;
      addr_r    <= 8'h00;
      err_r     <= 1'b0;
      bus_msg_r <= 16'h0000;
      bus_err_r <= 16'h0000;
      slv_msg_r <= 16'h0000;
      no_rsp_r  <= 16'h0000;
    end else if (step) begin
      crc_r     <= crc_nxt;
      cnt_r     <= cnt_nxt;
      addr_r    <= addr_nxt;
      err_r     <= err_nxt;
      bus_msg_r <= bus_msg_nxt;
      bus_err_r <= bus_err_nxt;
      slv_msg_r <= slv_msg_nxt;
      no_rsp_r  <= no_rsp_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= mbrtu_pkg::CNT_SAT)
    else $error("frame byte count beyond saturation");

  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.end_of_frame |=> cnt_r == '0 && crc_r == mbrtu_pkg::CRC_INIT && !err_r)
    else $error("frame state not cleared after last byte");

  a_one_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> (bus_msg_r - $past(bus_msg_r)) + (bus_err_r - $past(bus_err_r)) ==
             {15'd0, $past(item.end_of_frame)})
    else $error("frame verdict not counted exactly once");

  a_bcast_mine: assert property (@(posedge clk) disable iff (!rst_n)
    step && result.is_broadcast |-> result.for_this_slave && result.frame_valid)
    else $error("broadcast flagged on a frame not accepted");

endmodule

// ===== src/mbrtu_out_stage.sv =====
// result register towards the receiver, holds its contents while stalled
// depends on mbrtu_pkg (result_t)
module mbrtu_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  mbrtu_pkg::result_t  result,
  output logic                space,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_data_byte,
  output logic [7:0]          out_byte_index,
  output logic                out_frame_done,
  output logic                out_frame_valid,
  output logic                out_for_this_slave,
  output logic                out_is_broadcast,
  output logic [7:0]          out_pdu_length,
  output logic [15:0]         out_bus_message_count,
  output logic [15:0]         out_bus_error_count,
  output logic [15:0]         out_slave_message_count,
  output logic [15:0]         out_no_response_count
);

  logic               valid_r;
  mbrtu_pkg::result_t res_r;

  assign space     = !valid_r || out_ready;
  assign out_valid = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (space) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

  assign out_data_byte           = res_r.data_byte;
  assign out_byte_index          = res_r.byte_index;
  assign out_frame_done          = res_r.frame_done;
  assign out_frame_valid         = res_r.frame_valid;
  assign out_for_this_slave      = res_r.for_this_slave;
  assign out_is_broadcast        = res_r.is_broadcast;
  assign out_pdu_length          = res_r.pdu_length;
  assign out_bus_message_count   = res_r.bus_message_count;
  assign out_bus_error_count     = res_r.bus_error_count;
  assign out_slave_message_count = res_r.slave_message_count;
  assign out_no_response_count   = res_r.no_response_count;

endmodule

// ===== src/modbus_rtu_frame_checker_top.sv =====
// modbus rtu receive frame checker: slave address register and the three pipeline parts
// depends on mbrtu_pkg, mbrtu_in_stage, mbrtu_frame_core, mbrtu_out_stage
//
// usage
// - in_* channel: one received byte per request, with end_of_frame on the last
//   byte of a frame and line_error for a receive fault on that byte
// - out_* channel: one result per byte; the byte echoed with its frame index,
//   and on the last byte the verdict (crc-16/modbus residue, length 4 to 256,
//   no line error), address match, pdu length; the four wrapping message
//   counters are given on every result
// - cfg_* channel: writes the own slave address, always ready; write it only
//   while no request is in flight
// - pipeline: a byte accepted into the input register is checked and put in
//   the result register when it moves on; one byte per cycle is sustained
//   while out_ready is high, set by the crc update between the input and
//   result registers
// - a stalled receiver holds the result register; an empty input register
//   takes at most one more request, then in_ready stays low until out_ready returns
// - reset clears frame state, counters and both register valid flags; slave address 1
module modbus_rtu_frame_checker_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_end_of_frame,
  input  logic        in_line_error,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_data_byte,
  output logic [7:0]  out_byte_index,
  output logic        out_frame_done,
  output logic        out_frame_valid,
  output logic        out_for_this_slave,
  output logic        out_is_broadcast,
  output logic [7:0]  out_pdu_length,
  output logic [15:0] out_bus_message_count,
  output logic [15:0] out_bus_error_count,
  output logic [15:0] out_slave_message_count,
  output logic [15:0] out_no_response_count
);

  logic                cfg_write;
  logic [7:0]          slave_address_r;
  logic                item_valid;
  logic                space;
  logic                advance;
  mbrtu_pkg::in_item_t item;
  mbrtu_pkg::result_t  result;

  assign cfg_write = cfg_valid && cfg_ready;
  assign cfg_ready = 1'b1;
  assign advance   = item_valid && space;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_address_r <= mbrtu_pkg::SLAVE_ADDR_RST;
    end else if (cfg_write) begin
      slave_address_r <= cfg_data;
    end
  end

  mbrtu_in_stage u_in (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .in_end_of_frame (in_end_of_frame),
    .in_line_error   (in_line_error),
    .take            (advance),
    .item_valid      (item_valid),
    .item            (item)
  );

  mbrtu_frame_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (advance),
    .item          (item),
    .slave_address (slave_address_r),
    .result        (result)
  );

  mbrtu_out_stage u_out (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .load                    (advance),
    .result                  (result),
    .space                   (space),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_data_byte           (out_data_byte),
    .out_byte_index          (out_byte_index),
    .out_frame_done          (out_frame_done),
    .out_frame_valid         (out_frame_valid),
    .out_for_this_slave      (out_for_this_slave),
    .out_is_broadcast        (out_is_broadcast),
    .out_pdu_length          (out_pdu_length),
    .out_bus_message_count   (out_bus_message_count),
    .out_bus_error_count     (out_bus_error_count),
    .out_slave_message_count (out_slave_message_count),
    .out_no_response_count   (out_no_response_count)
  );

endmodule
